[rtl/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyword token scanner: token kinds,
// scan modes, the scan state and one result record.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned PrefixChars = 5;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QcntW       = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    KIND_NUM     = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_PRINT   = 4'd2,
    KIND_ASSIGN  = 4'd3,
    KIND_IF      = 4'd4,
    KIND_ELSE    = 4'd5,
    KIND_FOR     = 4'd6,
    KIND_WHILE   = 4'd7,
    KIND_DEF     = 4'd8,
    KIND_COLON   = 4'd9,
    KIND_NEWLINE = 4'd10,
    KIND_END     = 4'd11
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  // Packed keyword text, first character in the low byte.
  localparam logic [39:0] KW_PRINT = 40'h74_6E_69_72_70;
  localparam logic [39:0] KW_IF    = 40'h00_00_00_66_69;
  localparam logic [39:0] KW_ELSE  = 40'h00_65_73_6C_65;
  localparam logic [39:0] KW_FOR   = 40'h00_00_72_6F_66;
  localparam logic [39:0] KW_WHILE = 40'h65_6C_69_68_77;
  localparam logic [39:0] KW_DEF   = 40'h00_00_66_65_64;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_END     = 8'h00;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  run_length;
    logic [39:0] prefix;
    logic [15:0] counter;
  } scan_state_t;

  typedef struct packed {
    logic        is_char;
    logic [7:0]  char_value;
    logic [3:0]  token_kind;
    logic [7:0]  token_length;
    logic [15:0] token_index;
    logic        last;
  } token_rec_t;

  // Final kind of a closed identifier.
  function automatic logic [3:0] classify(input logic [7:0] len, input logic [39:0] prefix);
    logic [3:0] kind;
    kind = KIND_IDENT;
    if (len == 8'd5 && prefix == KW_PRINT) kind = KIND_PRINT;
    if (len == 8'd2 && prefix == KW_IF)    kind = KIND_IF;
    if (len == 8'd4 && prefix == KW_ELSE)  kind = KIND_ELSE;
    if (len == 8'd3 && prefix == KW_FOR)   kind = KIND_FOR;
    if (len == 8'd5 && prefix == KW_WHILE) kind = KIND_WHILE;
    if (len == 8'd3 && prefix == KW_DEF)   kind = KIND_DEF;
    return kind;
  endfunction

endpackage

[rtl/kts_step.sv]
// ----------------------------------------------------------------------------
// kts_step
// Per-byte scan logic: from the current state and one byte, form up to two
// result records and the next scan state.
// ----------------------------------------------------------------------------
module kts_step (
  input  logic [7:0]           char_in,
  input  kts_pkg::scan_state_t st,
  output kts_pkg::scan_state_t st_nxt,
  output kts_pkg::token_rec_t  rec0,
  output kts_pkg::token_rec_t  rec1,
  output logic [1:0]           nrec
);
  import kts_pkg::*;

  logic        is_dig;
  logic        is_let;
  logic        in_num;
  logic        in_ident;
  logic        cont;
  logic [7:0]  len_inc;
  logic [39:0] prefix_app;
  logic [15:0] cnt1;
  logic [15:0] cnt2;
  token_rec_t  rec_a;
  token_rec_t  rec_b;
  logic        have_a;
  logic        have_b;

  assign is_dig   = (char_in >= 8'h30) && (char_in <= 8'h39);
  assign is_let   = ((char_in >= 8'h61) && (char_in <= 8'h7A)) ||
                    ((char_in >= 8'h41) && (char_in <= 8'h5A));
  assign in_num   = (st.mode == MODE_NUM);
  assign in_ident = (st.mode == MODE_IDENT);
  assign cont     = (in_num && is_dig) || (in_ident && (is_dig || is_let));
  assign len_inc  = (st.run_length == 8'hFF) ? st.run_length : st.run_length + 8'd1;

  // Keep the first five identifier characters only.
  always_comb begin
    prefix_app = st.prefix;
    if (in_ident) begin
      case (st.run_length)
        8'd0:    prefix_app[7:0]   = char_in;
        8'd1:    prefix_app[15:8]  = char_in;
        8'd2:    prefix_app[23:16] = char_in;
        8'd3:    prefix_app[31:24] = char_in;
        8'd4:    prefix_app[39:32] = char_in;
        default: prefix_app = st.prefix;
      endcase
    end
  end

  always_comb begin
    st_nxt = '0;
    rec_a  = '0;
    rec_b  = '0;
    have_a = 1'b0;
    have_b = 1'b0;
    cnt1   = st.counter;
    cnt2   = st.counter;
    if (cont) begin
      st_nxt            = st;
      st_nxt.prefix     = prefix_app;
      st_nxt.run_length = len_inc;
      have_a            = 1'b1;
      rec_a.is_char     = 1'b1;
      rec_a.char_value  = char_in;
      rec_a.token_kind  = in_ident ? KIND_IDENT : KIND_NUM;
      rec_a.token_length = len_inc;
      rec_a.token_index = st.counter;
    end else begin
      if (in_num || in_ident) begin
        have_a             = 1'b1;
        rec_a.token_kind   = in_ident ? classify(st.run_length, st.prefix) : KIND_NUM;
        rec_a.token_length = st.run_length;
        rec_a.token_index  = st.counter;
        cnt1 = (st.counter == 16'hFFFF) ? st.counter : st.counter + 16'd1;
      end
      cnt2 = (cnt1 == 16'hFFFF) ? cnt1 : cnt1 + 16'd1;
      st_nxt.counter = cnt1;
      if (char_in == CH_END) begin
        have_b            = 1'b1;
        rec_b.token_kind  = KIND_END;
        rec_b.token_index = cnt1;
        st_nxt            = '0;
      end else if (is_dig || is_let) begin
        have_b             = 1'b1;
        st_nxt.mode        = is_dig ? MODE_NUM : MODE_IDENT;
        st_nxt.run_length  = 8'd1;
        st_nxt.prefix      = is_let ? {32'd0, char_in} : 40'd0;
        rec_b.is_char      = 1'b1;
        rec_b.char_value   = char_in;
        rec_b.token_kind   = is_dig ? KIND_NUM : KIND_IDENT;
        rec_b.token_length = 8'd1;
        rec_b.token_index  = cnt1;
      end else if (char_in == CH_NEWLINE || char_in == CH_ASSIGN || char_in == CH_COLON) begin
        have_b             = 1'b1;
        rec_b.char_value   = char_in;
        rec_b.token_kind   = (char_in == CH_NEWLINE) ? KIND_NEWLINE :
                             (char_in == CH_ASSIGN) ? KIND_ASSIGN : KIND_COLON;
        rec_b.token_length = 8'd1;
        rec_b.token_index  = cnt1;
        st_nxt.counter     = cnt2;
      end
    end
  end

  // Pack the records to the front and mark the last one.
  always_comb begin
    rec0 = have_a ? rec_a : rec_b;
    rec1 = rec_b;
    nrec = {1'b0, have_a} + {1'b0, have_b};
    rec0.last = !(have_a && have_b);
    rec1.last = 1'b1;
  end

endmodule

[rtl/keyword_token_scanner.sv]
// ----------------------------------------------------------------------------
// keyword_token_scanner
// Byte-wide lexer: numbers, identifiers, six keywords and one-byte tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_char_in carries one source byte
//   per item; byte 0 ends the text. The output channel out_valid / out_stall
//   carries result items: streamed token characters, token records and the
//   end record, each with out_last set on the final result of its byte.
//   A byte yields zero, one or two results.
//   Results of a byte are written into the result queue at the edge that
//   accepts it and, when the queue was empty, are visible right after it.
//   Throughput: one byte per cycle while in_stall is low. The scan state
//   updates in the cycle a byte is accepted; its records go to a four-entry
//   result queue that drains one item per cycle while out_stall is low, so
//   a run of two-result bytes is limited by the single output port.
//   in_stall rises while the queue has fewer than two free entries.
//   Reset (rst_n low, synchronous) empties the queue and returns the scan
//   state to idle with the token count at zero.
//   When the receiver stalls, the head item holds on the out_ ports.
// ----------------------------------------------------------------------------
module keyword_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_char,
  output logic [7:0]  out_char_value,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_token_length,
  output logic [15:0] out_token_index,
  output logic        out_last
);
  import kts_pkg::*;

  scan_state_t      state_r;
  scan_state_t      state_nxt;
  token_rec_t       rec0;
  token_rec_t       rec1;
  logic [1:0]       nrec;
  token_rec_t       q_r   [QueueDepth];
  token_rec_t       q_nxt [QueueDepth];
  logic [QcntW-1:0] qcnt_r;
  logic [QcntW-1:0] qcnt_nxt;
  logic [QcntW-1:0] base;
  logic [1:0]       push;
  logic             accept;
  logic             pop;

  // Scan logic for the byte on the input ports.
  kts_step u_step (
    .char_in (in_char_in),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .rec0    (rec0),
    .rec1    (rec1),
    .nrec    (nrec)
  );

  // Hold off input unless two entries are free.
  assign in_stall = (qcnt_r > QcntW'(QueueDepth - 2));
  assign accept   = in_valid && !in_stall;
  assign out_valid = (qcnt_r != '0);
  assign pop      = out_valid && !out_stall;
  assign push     = accept ? nrec : 2'd0;
  assign base     = qcnt_r - QcntW'(pop);
  assign qcnt_nxt = base + QcntW'(push);

  // Shift the queue on pop, append new records behind what remains.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      q_nxt[i] = q_r[i];
      if (pop && (i < QueueDepth - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end
      if (QcntW'(i) == base && push != 2'd0) begin
        q_nxt[i] = rec0;
      end
      if (QcntW'(i) == base + QcntW'(1) && push == 2'd2) begin
        q_nxt[i] = rec1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      qcnt_r  <= '0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      qcnt_r <= qcnt_nxt;
    end
  end

  // Queue payload carries no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_is_char      = q_r[0].is_char;
  assign out_char_value   = q_r[0].char_value;
  assign out_token_kind   = q_r[0].token_kind;
  assign out_token_length = q_r[0].token_length;
  assign out_token_index  = q_r[0].token_index;
  assign out_last         = q_r[0].last;

`ifndef SYNTHESIS
  // The queue never holds more entries than it has.
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QcntW'(QueueDepth))
    else $error("result queue overflow");

  // The end record always closes the results of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END |-> out_last)
    else $error("end record without last");

  // Streamed characters belong to a number or an identifier.
  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_char |->
      (out_token_kind == KIND_NUM || out_token_kind == KIND_IDENT))
    else $error("character with bad kind");

  // End of text returns the scanner to idle with the count cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_char_in == CH_END |=> state_r == '0)
    else $error("state not cleared after end of text");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyword_token_scanner. Feeds source bytes with
// random gaps, predicts each byte's result items with a behavioral lexer,
// and matches every result taken from the block against the oldest
// prediction. Covers keywords, token boundaries, long tokens, high bytes,
// end of text and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import kts_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_char;
  logic [7:0]  out_char_value;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_token_length;
  logic [15:0] out_token_index;
  logic        out_last;

  keyword_token_scanner uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_char     (out_is_char),
    .out_char_value  (out_char_value),
    .out_token_kind  (out_token_kind),
    .out_token_length(out_token_length),
    .out_token_index (out_token_index),
    .out_last        (out_last)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lexer state mirrored by the bench and the queue of predicted items.
  // --------------------------------------------------------------------------
  scan_mode_t  lx_mode   = MODE_IDLE;
  logic [7:0]  lx_len    = 8'd0;
  logic [39:0] lx_prefix = 40'd0;
  logic [15:0] lx_count  = 16'd0;
  token_rec_t  pending_tokens[$];

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int tx_max_gap     = 0;   // sender gap bound per item
  int rx_max_gap     = 0;   // receiver stall bound per item
  int hold_request   = 0;   // long receiver hold-off, in cycles
  int stall_left     = 0;

  string kw_list[6] = '{"print", "if", "else", "for", "while", "def"};

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Rebuild the word from the low-byte-first prefix and compare it as text.
  function automatic token_kind_t word_kind(input logic [7:0] len, input logic [39:0] pre);
    logic [39:0] word;
    word = 40'd0;
    if (len > 8'd5) return KIND_IDENT;
    for (int i = 0; i < len; i++) word = {word[31:0], pre[8*i +: 8]};
    if (len == 8'd5 && word == "print") return KIND_PRINT;
    if (len == 8'd2 && word == "if")    return KIND_IF;
    if (len == 8'd4 && word == "else")  return KIND_ELSE;
    if (len == 8'd3 && word == "for")   return KIND_FOR;
    if (len == 8'd5 && word == "while") return KIND_WHILE;
    if (len == 8'd3 && word == "def")   return KIND_DEF;
    return KIND_IDENT;
  endfunction

  function automatic void push_token(input logic is_char, input logic [7:0] ch,
                                     input logic [3:0] kind, input logic [7:0] len,
                                     input logic [15:0] idx);
    token_rec_t r;
    r.is_char      = is_char;
    r.char_value   = ch;
    r.token_kind   = kind;
    r.token_length = len;
    r.token_index  = idx;
    r.last         = 1'b0;
    pending_tokens.push_back(r);
  endfunction

  function automatic void bump_count();
    if (lx_count != 16'hFFFF) lx_count++;
  endfunction

  // Add a character to the open token and stream it out.
  function automatic void append_char(input logic [7:0] c);
    if (lx_mode == MODE_IDENT && lx_len < 8'd5) lx_prefix[8*lx_len +: 8] = c;
    if (lx_len != 8'hFF) lx_len++;
    push_token(1'b1, c, (lx_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUM, lx_len, lx_count);
  endfunction

  // Predict the items of one accepted byte.
  function automatic void lex_byte(input logic [7:0] c);
    int         first;
    token_rec_t r;
    token_kind_t kind;
    first = pending_tokens.size();
    if ((lx_mode == MODE_NUM && is_digit(c)) || (lx_mode == MODE_IDENT && is_alnum(c))) begin
      append_char(c);
    end else begin
      if (lx_mode == MODE_NUM || lx_mode == MODE_IDENT) begin
        kind = (lx_mode == MODE_IDENT) ? word_kind(lx_len, lx_prefix) : KIND_NUM;
        push_token(1'b0, 8'd0, kind, lx_len, lx_count);
        bump_count();
      end
      lx_mode   = MODE_IDLE;
      lx_len    = 8'd0;
      lx_prefix = 40'd0;
      if (c == CH_END) begin
        push_token(1'b0, 8'd0, KIND_END, 8'd0, lx_count);
        lx_count = 16'd0;
      end else if (is_alnum(c)) begin
        lx_mode = is_digit(c) ? MODE_NUM : MODE_IDENT;
        append_char(c);
      end else if (c == CH_NEWLINE || c == CH_ASSIGN || c == CH_COLON) begin
        kind = (c == CH_NEWLINE) ? KIND_NEWLINE : ((c == CH_ASSIGN) ? KIND_ASSIGN : KIND_COLON);
        push_token(1'b0, c, kind, 8'd1, lx_count);
        bump_count();
      end
    end
    // Flag the final item of this byte.
    if (pending_tokens.size() > first) begin
      r = pending_tokens.pop_back();
      r.last = 1'b1;
      pending_tokens.push_back(r);
    end
  endfunction

  function automatic string rec_str(input token_rec_t r);
    return $sformatf("is_char=%0b char=%02h kind=%0d len=%0d idx=%0d last=%0b",
                     r.is_char, r.char_value, r.token_kind, r.token_length,
                     r.token_index, r.last);
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check at the rising edge, drive out_stall at the falling
  // edge. Draw a fresh stall length after every taken item; a pending
  // hold-off request overrides it.
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    token_rec_t got;
    token_rec_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.is_char      = out_is_char;
        got.char_value   = out_char_value;
        got.token_kind   = out_token_kind;
        got.token_length = out_token_length;
        got.token_index  = out_token_index;
        got.last         = out_last;
        if (pending_tokens.size() == 0) begin
          note_error({"unexpected item: ", rec_str(got)});
        end else begin
          want = pending_tokens.pop_front();
          if (got.is_char != want.is_char || got.char_value != want.char_value ||
              got.token_kind != want.token_kind || got.token_length != want.token_length ||
              got.token_index != want.token_index || got.last != want.last)
            note_error({"expected ", rec_str(want), " got ", rec_str(got)});
        end
        stall_left = $urandom_range(0, rx_max_gap);
      end
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one byte after a random gap, hold it until taken, then predict.
  // Return right at the accepting edge so a back-to-back byte keeps valid up.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    lex_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid and wait until every predicted item has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty text, keyword, boundary bytes, one-byte tokens, high bytes,
  // skipped whitespace, and end of text closing an open keyword.
  task automatic test_directed();
    tx_max_gap = 3;
    rx_max_gap = 3;
    send_byte(CH_END);
    send_text("if x=12ab:\n");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h09);
    send_text("def");
    send_byte(CH_END);
  endtask

  // Hold the receiver off while bytes keep coming, so the queue fills and
  // in_stall rises.
  task automatic test_backpressure();
    tx_max_gap   = 0;
    rx_max_gap   = 0;
    hold_request = 60;
    for (int i = 0; i < 20; i++) send_text("x=");
    send_byte(CH_END);
  endtask

  // Length saturation on both token types; the long identifier starts as a
  // keyword but must not match.
  task automatic test_long_tokens();
    tx_max_gap = 2;
    rx_max_gap = 2;
    send_text("while");
    for (int i = 0; i < 260; i++) send_byte(rand_letter());
    send_byte(" ");
    for (int i = 0; i < 260; i++) send_byte(8'("0" + $urandom_range(0, 9)));
    send_text(";print ");
    send_byte(CH_END);
  endtask

  // Mostly plausible source text with random words, plus noise bytes and
  // occasional end-of-text. Retune the gap bounds every hundred bytes.
  task automatic test_random_text(input int n_bytes);
    int    stop_at;
    int    pick;
    int    len;
    int    next_retune;
    int    gap_opts[3];
    string w;
    gap_opts    = '{0, 3, 7};
    stop_at     = bytes_sent + n_bytes;
    next_retune = bytes_sent;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= next_retune) begin
        tx_max_gap  = gap_opts[$urandom_range(0, 2)];
        rx_max_gap  = gap_opts[$urandom_range(0, 2)];
        next_retune = bytes_sent + 100;
      end
      pick = $urandom_range(0, 15);
      case (pick)
        0, 1, 2, 3: begin
          send_text(kw_list[$urandom_range(0, 5)]);
        end
        4: begin
          // Near-miss keyword: extended, truncated or capitalized.
          w = kw_list[$urandom_range(0, 5)];
          case ($urandom_range(0, 2))
            0: w = {w, "s"};
            1: w = w.substr(0, w.len() - 2);
            default: w[0] = w[0] - 8'h20;
          endcase
          send_text(w);
        end
        5, 6: begin
          len = $urandom_range(1, 8);
          send_byte(rand_letter());
          for (int i = 1; i < len; i++)
            send_byte($urandom_range(0, 2) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
        end
        7, 8: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_byte(8'("0" + $urandom_range(0, 9)));
        end
        9, 10: begin
          case ($urandom_range(0, 2))
            0: send_byte(CH_ASSIGN);
            1: send_byte(CH_COLON);
            default: send_byte(CH_NEWLINE);
          endcase
        end
        11, 12: begin
          send_byte($urandom_range(0, 1) ? 8'h20 : 8'h09);
        end
        13: begin
          send_byte(8'($urandom_range(1, 255)));
        end
        14: begin
          send_byte($urandom_range(0, 3) ? 8'h20 : CH_END);
        end
        default: begin
          len = $urandom_range(20, 30);
          for (int i = 0; i < len; i++) send_byte(rand_letter());
        end
      endcase
      // Leave words adjacent half the time to hit token boundaries.
      if ($urandom_range(0, 1)) send_byte(8'h20);
    end
    send_byte(CH_END);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_char_in = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_long_tokens();
    wait_drain();
    test_random_text(850);
    wait_drain();

    // Catch stray items after the last expected one.
    repeat (20) @(posedge clk);
    if (pending_tokens.size() != 0) note_error("items still expected at end of run");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
